>>> rtl/core/mccu_pkg.sv
// Package of the multicycle cpu control unit: phase codes, decode constants,
// one-hot select codes, strobe positions and the result record.
// No dependencies.
`default_nettype none

package mccu_pkg;

  // phase codes
  localparam logic [2:0] PH_F    = 3'd0;
  localparam logic [2:0] PH_D    = 3'd1;
  localparam logic [2:0] PH_E    = 3'd2;
  localparam logic [2:0] PH_M    = 3'd3;
  localparam logic [2:0] PH_W    = 3'd4;
  localparam logic [2:0] PH_LAST = 3'd5;
  localparam logic [2:0] PH_IDLE = 3'd7;

  // item operations
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ACK  = 1'b1;

  // decode constants
  localparam logic [4:0] CALL_LINK_REG = 5'd15;
  localparam logic [4:0] OP_RESTSAVE   = 5'd30;
  localparam logic [4:0] OP_JMPL       = 5'd28;
  localparam logic [3:0] OP_ARIT_EXTRA = 4'd9;

  // op2 field of the branch format, bits 24..22
  localparam logic [2:0] OP2_UNIMP  = 3'd0;
  localparam logic [2:0] OP2_BRANCH = 3'd2;
  localparam logic [2:0] OP2_SETHI  = 3'd4;

  // upper op3 bits of the arithmetic format, bits 24..22
  localparam logic [2:0] OP3H_RD = 3'd5;
  localparam logic [2:0] OP3H_WR = 3'd6;

  // special register field, bits 21..19
  localparam logic [2:0] SPR_Y   = 3'd0;
  localparam logic [2:0] SPR_PSR = 3'd1;
  localparam logic [2:0] SPR_WIM = 3'd2;
  localparam logic [2:0] SPR_TBR = 3'd3;

  // ancillary register numbers on a read, bits 21..14
  localparam logic [7:0] ASR_Y    = 8'd0;
  localparam logic [7:0] ASR_BASE = 8'd1;
  localparam logic [7:0] ASR_LIM  = 8'd2;

  // destination numbers on a write to an ancillary register, bits 29..25
  localparam logic [4:0] WR_Y    = 5'd0;
  localparam logic [4:0] WR_BASE = 5'd1;
  localparam logic [4:0] WR_LIM  = 5'd2;

  // register write source, one-hot
  localparam logic [4:0] CSRC_ALU  = 5'b00001;
  localparam logic [4:0] CSRC_IMM  = 5'b00010;
  localparam logic [4:0] CSRC_PC   = 5'b00100;
  localparam logic [4:0] CSRC_LOAD = 5'b01000;
  localparam logic [4:0] CSRC_SPEC = 5'b10000;

  // next pc source, one-hot
  localparam logic [3:0] PCS_INC   = 4'b0001;
  localparam logic [3:0] PCS_ALU   = 4'b0010;
  localparam logic [3:0] PCS_ADDER = 4'b0100;

  // alu function codes outside arithmetic
  localparam logic [3:0] ALU_ADD = 4'd0;
  localparam logic [3:0] ALU_XOR = 4'd3;

  // special register select, one-hot
  localparam logic [5:0] SPEC_PSR  = 6'b000001;
  localparam logic [5:0] SPEC_Y    = 6'b000010;
  localparam logic [5:0] SPEC_TBR  = 6'b000100;
  localparam logic [5:0] SPEC_WIM  = 6'b001000;
  localparam logic [5:0] SPEC_LIM  = 6'b010000;
  localparam logic [5:0] SPEC_BASE = 6'b100000;

  // strobe positions that other logic looks at
  localparam int STB_COUNT = 41;
  localparam int STB_AS    = 36;

  typedef struct packed {
    logic [2:0]           phase_now;
    logic [4:0]           sel_a;
    logic [4:0]           sel_b;
    logic [4:0]           sel_c;
    logic [4:0]           c_source;
    logic [3:0]           alu_func;
    logic [3:0]           pc_source;
    logic [1:0]           align_size;
    logic [5:0]           special_sel;
    logic [STB_COUNT-1:0] strobes;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/mccu_intf.sv
// Channel interfaces of the multicycle cpu control unit: the input beat
// (operation, instruction, condition, acknowledge) and the result beat.
// Depends on mccu_pkg.
`default_nettype none

interface mccu_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] instruction;
  logic        cond_true;
  logic        ack_value;

  modport source (output valid, output operation, output instruction,
                  output cond_true, output ack_value, input ready);
  modport sink   (input valid, input operation, input instruction,
                  input cond_true, input ack_value, output ready);
endinterface

interface mccu_out_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    phase_now;
  logic [4:0]                    sel_a;
  logic [4:0]                    sel_b;
  logic [4:0]                    sel_c;
  logic [4:0]                    c_source;
  logic [3:0]                    alu_func;
  logic [3:0]                    pc_source;
  logic [1:0]                    align_size;
  logic [5:0]                    special_sel;
  logic [mccu_pkg::STB_COUNT-1:0] strobes;

  modport source (output valid, output phase_now, output sel_a, output sel_b,
                  output sel_c, output c_source, output alu_func, output pc_source,
                  output align_size, output special_sel, output strobes,
                  input ready);
  modport sink   (input valid, input phase_now, input sel_a, input sel_b,
                  input sel_c, input c_source, input alu_func, input pc_source,
                  input align_size, input special_sel, input strobes,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/mccu_decode.sv
// Instruction decoder of the multicycle cpu control unit: turns the new phase
// and the instruction word into selects, alu code and strobes.
// Depends on mccu_pkg.
`default_nettype none

module mccu_decode (
  input  wire logic [2:0]  phase,
  input  wire logic [31:0] instr,
  input  wire logic        cond_true,
  input  wire logic [5:0]  special_hold,
  input  wire logic        halt_flag,
  output mccu_pkg::result_t res,
  output logic [5:0]       special_next,
  output logic             halt_next
);

  logic f_f, f_d, f_e, f_m, f_w;
  logic fmt2, fmt3;
  logic is_branch, is_unimp, is_sethi, is_arit, is_restsave, is_jmp;
  logic is_rd, is_wr, is_muldiv, is_mul, is_call, is_load, is_store;
  logic [2:0] sp3;
  logic [7:0] asr;
  logic en_mul, en_alu, en_shft, as_stb;
  logic [mccu_pkg::STB_COUNT-1:0] s;

  // phase flags
  assign f_f = (phase == mccu_pkg::PH_F);
  assign f_d = (phase == mccu_pkg::PH_D);
  assign f_e = (phase == mccu_pkg::PH_E);
  assign f_m = (phase == mccu_pkg::PH_M);
  assign f_w = (phase == mccu_pkg::PH_W);

  // instruction classes
  assign fmt2        = !instr[31] && !instr[30];
  assign fmt3        = instr[31] && !instr[30];
  assign is_branch   = fmt2 && (instr[24:22] == mccu_pkg::OP2_BRANCH);
  assign is_unimp    = fmt2 && (instr[24:22] == mccu_pkg::OP2_UNIMP);
  assign is_sethi    = fmt2 && (instr[24:22] == mccu_pkg::OP2_SETHI);
  assign is_arit     = fmt3 && (!instr[24] || (instr[24:21] == mccu_pkg::OP_ARIT_EXTRA));
  assign is_restsave = fmt3 && (instr[24:20] == mccu_pkg::OP_RESTSAVE);
  assign is_jmp      = fmt3 && (instr[24:20] == mccu_pkg::OP_JMPL);
  assign is_rd       = fmt3 && (instr[24:22] == mccu_pkg::OP3H_RD);
  assign is_wr       = fmt3 && (instr[24:22] == mccu_pkg::OP3H_WR);
  assign is_muldiv   = !instr[24] && instr[22] && instr[20];
  assign is_mul      = is_muldiv && !instr[19];
  assign is_call     = !instr[31] && instr[30];
  assign is_load     = instr[31] && instr[30] && !instr[21];
  assign is_store    = instr[31] && instr[30] && instr[21];
  assign sp3         = instr[21:19];
  assign asr         = instr[21:14];

  // execution unit enables
  assign en_mul  = is_arit && is_muldiv;
  assign en_shft = is_arit && instr[24];
  assign en_alu  = !is_arit || (!instr[24] && !is_muldiv);

  assign as_stb = f_f || (f_m && is_load) || (f_w && is_store);

  // special select held across decodes, first match wins
  always_comb begin
    special_next = special_hold;
    if (f_d && is_rd) begin
      priority if (sp3 == mccu_pkg::SPR_PSR)  special_next = mccu_pkg::SPEC_PSR;
      else if (asr == mccu_pkg::ASR_Y)        special_next = mccu_pkg::SPEC_Y;
      else if (sp3 == mccu_pkg::SPR_TBR)      special_next = mccu_pkg::SPEC_TBR;
      else if (sp3 == mccu_pkg::SPR_WIM)      special_next = mccu_pkg::SPEC_WIM;
      else if (asr == mccu_pkg::ASR_LIM)      special_next = mccu_pkg::SPEC_LIM;
      else if (asr == mccu_pkg::ASR_BASE)     special_next = mccu_pkg::SPEC_BASE;
      else                                    special_next = special_hold;
    end
  end

  // halt sticks once an unimplemented word is decoded
  assign halt_next = halt_flag || (f_d && is_unimp);

  // strobe vector in port order
  always_comb begin
    s[0]  = f_w && !is_branch && !is_store && !is_wr;
    s[1]  = f_m;
    s[2]  = 1'b1;
    s[3]  = f_d;
    s[4]  = !instr[13];
    s[5]  = f_d;
    s[6]  = en_mul;
    s[7]  = en_alu;
    s[8]  = en_shft;
    s[9]  = f_e;
    s[10] = f_w && (is_mul || (is_wr && sp3 == mccu_pkg::SPR_Y &&
                               instr[29:25] == mccu_pkg::WR_Y));
    s[11] = f_e || (f_m && is_wr);
    s[12] = f_m;
    s[13] = f_w;
    s[14] = f_m;
    s[15] = f_w;
    s[16] = is_call;
    s[17] = f_f;
    s[18] = f_f;
    s[19] = f_m;
    s[20] = f_m;
    s[21] = instr[22];
    s[22] = is_jmp || instr[19];
    s[23] = f_e || (f_m && is_wr);
    s[24] = f_w && (is_restsave || (is_jmp && instr[19]) ||
                    (is_wr && sp3 == mccu_pkg::SPR_PSR));
    s[25] = f_e || (f_m && is_wr);
    s[26] = f_w && ((is_arit && instr[23]) || (is_wr && sp3 == mccu_pkg::SPR_PSR));
    s[27] = is_wr;
    s[28] = is_wr;
    s[29] = is_wr;
    s[30] = is_wr;
    s[31] = f_w && is_wr && sp3 == mccu_pkg::SPR_TBR;
    s[32] = f_w && is_wr && sp3 == mccu_pkg::SPR_TBR;
    s[33] = f_w && is_wr && sp3 == mccu_pkg::SPR_WIM;
    s[34] = f_w && is_wr && sp3 == mccu_pkg::SPR_Y && instr[29:25] == mccu_pkg::WR_LIM;
    s[35] = f_w && is_wr && sp3 == mccu_pkg::SPR_Y && instr[29:25] == mccu_pkg::WR_BASE;
    s[36] = as_stb;
    s[37] = f_f || !is_store;
    s[38] = as_stb;
    s[39] = 1'b0;
    s[40] = halt_next;
  end

  // selects and codes
  always_comb begin
    res.phase_now = phase;
    res.sel_a = ((f_m || f_w) && is_store) ? instr[29:25] : instr[18:14];
    res.sel_b = instr[4:0];
    res.sel_c = (!f_f && is_call) ? mccu_pkg::CALL_LINK_REG : instr[29:25];

    priority if (is_arit || is_restsave) res.c_source = mccu_pkg::CSRC_ALU;
    else if (is_sethi)                   res.c_source = mccu_pkg::CSRC_IMM;
    else if (is_load)                    res.c_source = mccu_pkg::CSRC_LOAD;
    else if (is_rd)                      res.c_source = mccu_pkg::CSRC_SPEC;
    else                                 res.c_source = mccu_pkg::CSRC_PC;

    priority if (is_arit) res.alu_func = instr[22:19];
    else if (is_wr)       res.alu_func = mccu_pkg::ALU_XOR;
    else                  res.alu_func = mccu_pkg::ALU_ADD;

    priority if (is_jmp)                          res.pc_source = mccu_pkg::PCS_ALU;
    else if (is_call || (is_branch && cond_true)) res.pc_source = mccu_pkg::PCS_ADDER;
    else                                          res.pc_source = mccu_pkg::PCS_INC;

    res.align_size  = instr[20:19];
    res.special_sel = special_next;
    res.strobes     = s;
  end

endmodule

`default_nettype wire

>>> rtl/core/multicycle_cpu_control_unit.sv
// Top level of the multicycle cpu control unit: phase sequencer, memory wait,
// held special select, sticky halt and the result register.
// Depends on mccu_pkg, mccu_intf and mccu_decode.
`default_nettype none

// Each input beat is either a clock tick or a memory acknowledge. A tick that
// is not held by a pending memory wait advances the phase (fetch, decode,
// execute, memory, writeback, dead, then fetch again) and yields one result
// beat with the full decode of the instruction for the new phase; a tick
// during the wait and any acknowledge yield nothing. An acknowledge with level
// 1 ends the wait that the bus strobe of the previous result armed. Input is
// taken every cycle while the result register is empty or being drained, and
// a result appears in the cycle after its tick is taken; with out.ready high
// one input beat per cycle is taken, and the memory wait holds back results.
module multicycle_cpu_control_unit (
  input  wire logic   clk,
  input  wire logic   rst,
  mccu_in_if.sink     in,
  mccu_out_if.source  out
);

  logic [2:0]        phase;
  logic [2:0]        phase_next;
  logic              wait_mem;
  logic [5:0]        special_hold;
  logic [5:0]        special_next;
  logic              halt_flag;
  logic              halt_next;
  logic              in_fire;
  logic              emit;
  logic              out_valid;
  mccu_pkg::result_t dec_res;
  mccu_pkg::result_t res_reg;

  // take a beat whenever the result register can hold what it makes
  assign in.ready = !out_valid || out.ready;
  assign in_fire  = in.valid && in.ready;
  assign emit     = in_fire && (in.operation == mccu_pkg::OP_TICK) && !wait_mem;

  // phase advance, dead or idle goes to fetch
  assign phase_next = (phase >= mccu_pkg::PH_LAST) ? mccu_pkg::PH_F : phase + 3'd1;

  mccu_decode u_decode (
    .phase        (phase_next),
    .instr        (in.instruction),
    .cond_true    (in.cond_true),
    .special_hold (special_hold),
    .halt_flag    (halt_flag),
    .res          (dec_res),
    .special_next (special_next),
    .halt_next    (halt_next)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= mccu_pkg::PH_IDLE;
      wait_mem     <= 1'b0;
      special_hold <= '0;
      halt_flag    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (emit) begin
        phase        <= phase_next;
        wait_mem     <= dec_res.strobes[mccu_pkg::STB_AS];
        special_hold <= special_next;
        halt_flag    <= halt_next;
      end else if (in_fire && (in.operation == mccu_pkg::OP_ACK) && in.ack_value) begin
        wait_mem <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      res_reg <= dec_res;
    end
  end

  assign out.valid       = out_valid;
  assign out.phase_now   = res_reg.phase_now;
  assign out.sel_a       = res_reg.sel_a;
  assign out.sel_b       = res_reg.sel_b;
  assign out.sel_c       = res_reg.sel_c;
  assign out.c_source    = res_reg.c_source;
  assign out.alu_func    = res_reg.alu_func;
  assign out.pc_source   = res_reg.pc_source;
  assign out.align_size  = res_reg.align_size;
  assign out.special_sel = res_reg.special_sel;
  assign out.strobes     = res_reg.strobes;

endmodule

`default_nettype wire
